// ===== hdl/gucp_pkg.sv =====
// gucp_pkg: widths, register codes, constants and helper functions for the
// graded unfolding category probability pipeline. No dependencies.
package gucp_pkg;

  localparam int MAX_CATEGORIES_DEF = 5;
  localparam int NUM_THRESH         = 5;
  localparam int MAX_LANES          = 2 * NUM_THRESH;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int DISC_W      = 15;
  localparam int POS_W       = 16;
  localparam int CAT_W       = 3;
  localparam int PROB_W      = 17;

  localparam int DIFF_W  = POS_W + 1;
  localparam int MULT_W  = 4;
  localparam int TSUM_W  = POS_W + 3;
  localparam int W_W     = 22;
  localparam int Z_W     = 37;
  localparam int U_W     = Z_W + 2;
  localparam int U16_W   = U_W - 8;
  localparam int UC_W    = 22;
  localparam int T_W     = 39;
  localparam int N_W     = 5;
  localparam int F_W     = 16;
  localparam int V_W     = 31;
  localparam int FRAC_Q  = 30;
  localparam int PRD_W   = 2 * V_W;
  localparam int PAIR_W  = V_W + 1;
  localparam int DEN_W   = PAIR_W + 3;
  localparam int QUO_W   = 17;
  localparam int NN_W    = PAIR_W + 16 + 2;

  localparam logic [16:0]        LOG2E_Q16  = 17'd94548;
  localparam logic [U16_W-1:0]   EXP_LIMIT  = U16_W'(40 << 16);
  localparam logic [6:0]         N_LIMIT    = 7'd31;
  localparam logic [V_W-1:0]     V_ONE      = V_W'(1 << FRAC_Q);
  localparam logic [PRD_W-1:0]   ROUND_HALF = PRD_W'(1 << (FRAC_Q - 1));
  localparam logic [PROB_W-1:0]  PROB_ONE   = PROB_W'(65536);
  localparam logic signed [Z_W-1:0] Z_MIN   = {1'b1, {(Z_W-1){1'b0}}};

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DISCRIMINATION = 3'd0,
    REG_LOCATION       = 3'd1,
    REG_NUM_CATEGORIES = 3'd2,
    REG_THRESHOLD_0    = 3'd3,
    REG_THRESHOLD_1    = 3'd4,
    REG_THRESHOLD_2    = 3'd5,
    REG_THRESHOLD_3    = 3'd6,
    REG_THRESHOLD_4    = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic                 missing;
    logic                 out_zero;
    logic [CAT_W-1:0]     choice;
    logic [CAT_W-1:0]     keff;
    logic [MAX_LANES-1:0] lane_ok;
  } side_t;

  typedef logic [V_W-1:0] factor_tab_t [0:F_W];

  function automatic longint unsigned round_isqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    longint unsigned x;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    x = n;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n - r * r > r) r = r + 1;
    return r;
  endfunction

  // 2^(-2^-j) in q30
  function automatic factor_tab_t exp_factors();
    factor_tab_t     tab;
    longint unsigned c;
    c = 64'd1 << 29;
    tab[0] = V_W'(c);
    for (int j = 1; j <= F_W; j++) begin
      c = round_isqrt(c << 30);
      tab[j] = V_W'(c);
    end
    return tab;
  endfunction

  localparam factor_tab_t EXP_FACTOR = exp_factors();

  function automatic logic [V_W-1:0] exp_step(input logic [V_W-1:0] v,
                                              input logic [V_W-1:0] c);
    logic [PRD_W-1:0] p;
    p = PRD_W'(v) * PRD_W'(c) + ROUND_HALF;
    return p[V_W+FRAC_Q-1:FRAC_Q];
  endfunction

  function automatic logic signed [Z_W-1:0] smax(input logic signed [Z_W-1:0] a,
                                                 input logic signed [Z_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== hdl/gucp_if.sv =====
// gucp_if: valid/ready channel interfaces for input and result beats.
// Depends on gucp_pkg for field widths.
interface gucp_item_if;
  import gucp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CAT_W-1:0]         chosen_category;
  logic                     choice_missing;
  logic signed [POS_W-1:0]  person_position;
  modport source(output valid, chosen_category, choice_missing, person_position,
                 input ready);
  modport sink(input valid, chosen_category, choice_missing, person_position,
               output ready);
endinterface

interface gucp_result_if;
  import gucp_pkg::*;
  logic              valid;
  logic              ready;
  logic [PROB_W-1:0] probability;
  modport source(output valid, probability, input ready);
  modport sink(input valid, probability, output ready);
endinterface

// ===== hdl/graded_unfolding_category_probability_top.sv =====
// graded_unfolding_category_probability_top: pipelined category probability
// of the graded unfolding model. Depends on gucp_pkg and gucp_if.
//
// Takes one beat per clock while the output is not stalled and returns one
// probability beat per input beat, in order. The pipeline holds the sixteen
// multiply stages of the exponential in each of the 2*MAX_CATEGORIES lanes
// and the seventeen compare-subtract stages of the final divider. A stall
// at the output holds the whole pipeline. Registers must be written through
// cfg_we/cfg_index/cfg_wdata while no beat is in flight; not enforced here.
module graded_unfolding_category_probability_top #(
  parameter int MAX_CATEGORIES = gucp_pkg::MAX_CATEGORIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [gucp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gucp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  gucp_item_if.sink                          item,
  gucp_result_if.source                      result
);
  import gucp_pkg::*;

  localparam int NL    = 2 * MAX_CATEGORIES;
  localparam int S_IN  = 0;
  localparam int S_W   = 1;
  localparam int S_MX4 = 6;
  localparam int S_T   = 8;
  localparam int S_SH  = S_T + F_W + 1;
  localparam int S_P   = S_SH + 1;
  localparam int S_D3  = S_P + 3;
  localparam int S_N   = S_D3 + 1;
  localparam int S_O   = S_N + QUO_W + 1;
  localparam int NS    = S_O + 1;

  // configuration
  logic [DISC_W-1:0]        discrimination;
  logic signed [POS_W-1:0]  location;
  logic [CAT_W-1:0]         num_categories;
  logic signed [POS_W-1:0]  thresh [NUM_THRESH];

  always_ff @(posedge clk) begin
    if (rst) begin
      discrimination <= DISC_W'(4096);
      location       <= '0;
      num_categories <= CAT_W'(2);
      for (int i = 0; i < NUM_THRESH; i++) thresh[i] <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_DISCRIMINATION: discrimination <= cfg_wdata[DISC_W-1:0];
        REG_LOCATION:       location       <= cfg_wdata;
        REG_NUM_CATEGORIES: num_categories <= cfg_wdata[CAT_W-1:0];
        REG_THRESHOLD_0:    thresh[0]      <= cfg_wdata;
        REG_THRESHOLD_1:    thresh[1]      <= cfg_wdata;
        REG_THRESHOLD_2:    thresh[2]      <= cfg_wdata;
        REG_THRESHOLD_3:    thresh[3]      <= cfg_wdata;
        REG_THRESHOLD_4:    thresh[4]      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [CAT_W-1:0]          keff;
  logic [MAX_LANES-1:0]      lane_ok;
  logic signed [TSUM_W-1:0]  tsum [NUM_THRESH];

  always_comb begin
    if (num_categories == '0) begin
      keff = CAT_W'(1);
    end else if (num_categories > CAT_W'(MAX_CATEGORIES)) begin
      keff = CAT_W'(MAX_CATEGORIES);
    end else begin
      keff = num_categories;
    end
    for (int j = 0; j < MAX_LANES; j++) begin
      lane_ok[j] = (j < NL) && (CAT_W'(j / 2) < keff);
    end
    tsum[0] = TSUM_W'(thresh[0]);
    for (int k = 1; k < NUM_THRESH; k++) begin
      tsum[k] = tsum[k-1] + TSUM_W'(thresh[k]);
    end
  end

  // pipeline control
  logic          adv;
  logic [NS-1:0] vld;
  side_t         side_q [NS];

  assign adv          = !vld[NS-1] || result.ready;
  assign item.ready   = adv;
  assign result.valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], item.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[S_IN].missing  <= item.choice_missing;
      side_q[S_IN].out_zero <= item.chosen_category >= keff;
      side_q[S_IN].choice   <= item.chosen_category;
      side_q[S_IN].keff     <= keff;
      side_q[S_IN].lane_ok  <= lane_ok;
      for (int s = 1; s < NS; s++) side_q[s] <= side_q[s-1];
    end
  end

  // input stage and per-lane exponent arguments
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [W_W-1:0]    w_q [NL];
  logic signed [Z_W-1:0]    zp_q [5][NL];

  always_ff @(posedge clk) begin
    if (adv) begin
      diff_q <= DIFF_W'(item.person_position) - DIFF_W'(location);
    end
  end

  always_ff @(posedge clk) begin
    logic [MULT_W-1:0] m;
    if (adv) begin
      for (int j = 0; j < NL; j++) begin
        if (j % 2 == 0) begin
          m = MULT_W'(j / 2);
        end else begin
          m = MULT_W'({side_q[S_IN].keff, 1'b0}) - MULT_W'(1) - MULT_W'(j / 2);
        end
        w_q[j] <= W_W'($signed({1'b0, m})) * W_W'(diff_q) - W_W'(tsum[j / 2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NL; j++) begin
        zp_q[0][j] <= side_q[S_W].lane_ok[j]
                      ? Z_W'($signed({1'b0, discrimination})) * Z_W'(w_q[j])
                      : Z_MIN;
      end
      for (int s = 1; s < 5; s++) zp_q[s] <= zp_q[s-1];
    end
  end

  // largest exponent, registered tree
  logic signed [Z_W-1:0] leaf [16];
  logic signed [Z_W-1:0] mx1_q [8];
  logic signed [Z_W-1:0] mx2_q [4];
  logic signed [Z_W-1:0] mx3_q [2];
  logic signed [Z_W-1:0] mx4_q;

  always_comb begin
    for (int j = 0; j < 16; j++) leaf[j] = Z_MIN;
    for (int j = 0; j < NL; j++) leaf[j] = zp_q[0][j];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 8; i++) mx1_q[i] <= smax(leaf[2*i], leaf[2*i+1]);
      for (int i = 0; i < 4; i++) mx2_q[i] <= smax(mx1_q[2*i], mx1_q[2*i+1]);
      for (int i = 0; i < 2; i++) mx3_q[i] <= smax(mx2_q[2*i], mx2_q[2*i+1]);
      mx4_q <= smax(mx3_q[0], mx3_q[1]);
    end
  end

  // distance below the maximum, then times log2 e
  logic [UC_W-1:0]  uc_q [NL];
  logic             zu_q [NL];
  logic [N_W-1:0]   n_q  [F_W+1][NL];
  logic [F_W-1:0]   f_q  [F_W+1][NL];
  logic             ez_q [F_W+1][NL];
  logic [V_W-1:0]   v_q  [1:F_W][NL];

  always_ff @(posedge clk) begin
    logic signed [U_W-1:0] ur;
    logic [U16_W-1:0]      u16;
    if (adv) begin
      for (int j = 0; j < NL; j++) begin
        ur  = U_W'(mx4_q) - U_W'(zp_q[4][j]) + U_W'(128);
        u16 = ur[U_W-1:8];
        uc_q[j] <= (u16 > EXP_LIMIT) ? '0 : u16[UC_W-1:0];
        zu_q[j] <= (u16 > EXP_LIMIT) || !side_q[S_MX4].lane_ok[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [T_W-1:0] t;
    if (adv) begin
      for (int j = 0; j < NL; j++) begin
        t = T_W'(uc_q[j]) * T_W'(LOG2E_Q16);
        n_q[0][j]  <= t[32+N_W-1:32];
        f_q[0][j]  <= t[31:16];
        ez_q[0][j] <= zu_q[j] || (t[T_W-1:32] >= N_LIMIT);
      end
    end
  end

  // one factor 2^(-2^-e) per stage
  for (genvar e = 1; e <= F_W; e++) begin : g_exp
    logic [V_W-1:0] vin [NL];
    if (e == 1) begin : g_first
      always_comb for (int j = 0; j < NL; j++) vin[j] = V_ONE;
    end else begin : g_rest
      always_comb for (int j = 0; j < NL; j++) vin[j] = v_q[e-1][j];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int j = 0; j < NL; j++) begin
          n_q[e][j]  <= n_q[e-1][j];
          f_q[e][j]  <= f_q[e-1][j];
          ez_q[e][j] <= ez_q[e-1][j];
          v_q[e][j]  <= f_q[e-1][j][F_W-e] ? exp_step(vin[j], EXP_FACTOR[e]) : vin[j];
        end
      end
    end
  end

  // integer part of the exponent, rounded shift
  logic [V_W-1:0] term_q [NL];

  always_ff @(posedge clk) begin
    logic [V_W-1:0] h;
    logic [V_W:0]   hr;
    if (adv) begin
      for (int j = 0; j < NL; j++) begin
        h  = v_q[F_W][j] >> (n_q[F_W][j] - N_W'(1));
        hr = (V_W+1)'(h) + (V_W+1)'(1);
        if (ez_q[F_W][j]) begin
          term_q[j] <= '0;
        end else if (n_q[F_W][j] == '0) begin
          term_q[j] <= v_q[F_W][j];
        end else begin
          term_q[j] <= hr[V_W:1];
        end
      end
    end
  end

  // category terms, chosen numerator and denominator tree
  logic [PAIR_W-1:0]  pc [8];
  logic [PAIR_W-1:0]  numc;
  logic [PAIR_W-1:0]  pr_q [8];
  logic [PAIR_W-1:0]  num_q [4];
  logic [PAIR_W:0]    s4_q [4];
  logic [PAIR_W+1:0]  s2_q [2];
  logic [DEN_W-1:0]   den_q [QUO_W+2];
  logic [DEN_W-1:0]   rem_q [QUO_W+1];
  logic [QUO_W-1:0]   low_q [QUO_W+1];
  logic [QUO_W-1:0]   quo_q [QUO_W+1];
  logic [PROB_W-1:0]  prob_q;

  always_comb begin
    for (int k = 0; k < 8; k++) pc[k] = '0;
    numc = '0;
    for (int k = 0; k < MAX_CATEGORIES; k++) begin
      pc[k] = PAIR_W'(term_q[2*k]) + PAIR_W'(term_q[2*k+1]);
      if (CAT_W'(k) == side_q[S_SH].choice) numc = pc[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_q     <= pc;
      num_q[0] <= numc;
      for (int i = 0; i < 4; i++) s4_q[i] <= (PAIR_W+1)'(pr_q[2*i]) + (PAIR_W+1)'(pr_q[2*i+1]);
      for (int i = 0; i < 2; i++) s2_q[i] <= (PAIR_W+2)'(s4_q[2*i]) + (PAIR_W+2)'(s4_q[2*i+1]);
      den_q[0] <= DEN_W'(s2_q[0]) + DEN_W'(s2_q[1]);
      for (int s = 1; s < 4; s++) num_q[s] <= num_q[s-1];
    end
  end

  // rounded quotient, one bit a stage
  always_ff @(posedge clk) begin
    logic [NN_W-1:0] nn;
    if (adv) begin
      nn = (NN_W'(num_q[3]) << 16) + NN_W'(den_q[0] >> 1);
      rem_q[0] <= DEN_W'(nn >> QUO_W);
      low_q[0] <= nn[QUO_W-1:0];
      quo_q[0] <= '0;
      den_q[1] <= den_q[0];
    end
  end

  for (genvar i = 1; i <= QUO_W; i++) begin : g_div
    logic [DEN_W:0] rs;
    logic           ge;
    assign rs = {rem_q[i-1], low_q[i-1][QUO_W-i]};
    assign ge = rs >= {1'b0, den_q[i]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[i]   <= ge ? DEN_W'(rs - {1'b0, den_q[i]}) : DEN_W'(rs);
        low_q[i]   <= low_q[i-1];
        quo_q[i]   <= {quo_q[i-1][QUO_W-2:0], ge};
        den_q[i+1] <= den_q[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (side_q[S_O-1].missing) begin
        prob_q <= PROB_ONE;
      end else if (side_q[S_O-1].out_zero) begin
        prob_q <= '0;
      end else begin
        prob_q <= PROB_W'(quo_q[QUO_W]);
      end
    end
  end

  assign result.probability = prob_q;

  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> !result.valid)
    else $error("result beat right after reset");

  a_den_floor: assert property (@(posedge clk) disable iff (rst)
    vld[S_D3] |-> den_q[0] >= DEN_W'(V_ONE))
    else $error("denominator below the largest term");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld[S_O-1] |-> rem_q[QUO_W] < den_q[QUO_W+1])
    else $error("divider remainder not below denominator");

  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    vld[S_O-1] |-> quo_q[QUO_W] <= PROB_ONE)
    else $error("quotient above one");

endmodule
